/* hw/rtl/lps_pkg.sv */
// Shared types and constants for the LED pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

    // Design constants
    localparam int unsigned LED_W      = 6;
    localparam logic [3:0]  LED_COUNT  = 4'd6;
    localparam logic [3:0]  WALK_STEPS = 4'd12;
    localparam logic [3:0]  PAIR_STEPS = 4'd6;

    localparam logic [7:0]  KEEP_MASK  = 8'h30;
    localparam logic [7:0]  LEVEL_HI   = 8'hC0;
    localparam logic [7:0]  ON_LED0    = 8'h01;
    localparam logic [7:0]  ON_LED03   = 8'h09;
    localparam logic [7:0]  FIXED_A    = 8'h09;
    localparam logic [7:0]  FIXED_B    = 8'h06;
    localparam logic [7:0]  PAIR_LOW   = 8'h03;
    localparam logic [7:0]  PAIR_HIGH  = 8'h0C;

    // Handshake flag codes
    localparam logic [7:0]  HS_IDLE      = 8'd0;
    localparam logic [7:0]  HS_CLEARED   = 8'd1;
    localparam logic [7:0]  HS_WALK_DONE = 8'd2;
    localparam logic [7:0]  HS_PAIR_DONE = 8'd8;

    // Mode codes
    localparam logic [7:0]  MODE_CLEAR   = 8'd0;
    localparam logic [7:0]  MODE_WALK    = 8'd1;
    localparam logic [7:0]  MODE_BLINK0  = 8'd2;
    localparam logic [7:0]  MODE_LEVEL   = 8'd3;
    localparam logic [7:0]  MODE_BLINK03 = 8'd4;
    localparam logic [7:0]  MODE_FIXED_A = 8'd5;
    localparam logic [7:0]  MODE_FIXED_B = 8'd6;
    localparam logic [7:0]  MODE_PAIRS   = 8'd7;

    // Configuration port
    localparam int unsigned APB_ADDR_W   = 3;
    localparam int unsigned APB_DATA_W   = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_TICK_DIVIDE = 3'd0;
    localparam logic [3:0]  TICK_DIVIDE_RST = 4'd4;

    // One input beat
    typedef struct packed {
        logic [7:0] mode;
        logic       flag_write_valid;
        logic [7:0] flag_write_value;
        logic [7:0] level_pattern;
    } lps_item_t;

    // Sequencer state
    typedef struct packed {
        logic [LED_W-1:0] led_latch;
        logic [7:0]       pattern_byte;
        logic             blink_phase;
        logic [3:0]       tick_count;
        logic [3:0]       step_count;
        logic [7:0]       handshake;
    } lps_state_t;

endpackage : lps_pkg

`default_nettype wire

/* hw/rtl/lps_if.sv */
// Valid/ready channel interfaces for the LED pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none

interface lps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] mode;
    logic       flag_write_valid;
    logic [7:0] flag_write_value;
    logic [7:0] level_pattern;

    modport source (
        output valid, mode, flag_write_valid, flag_write_value, level_pattern,
        input  ready
    );
    modport sink (
        input  valid, mode, flag_write_valid, flag_write_value, level_pattern,
        output ready
    );
endinterface : lps_in_if

interface lps_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] led_drive;
    logic [7:0] handshake_flag;

    modport source (
        output valid, led_drive, handshake_flag,
        input  ready
    );
    modport sink (
        input  valid, led_drive, handshake_flag,
        output ready
    );
endinterface : lps_out_if

`default_nettype wire

/* hw/rtl/led_pattern_sequencer_core.sv */
// Top level of the LED pattern sequencer: input stage, tick logic, result stage.
`timescale 1ns / 1ps
`default_nettype none

// Each input beat is one slow tick. It carries the mode, an optional write of
// the handshake flag and a level pattern; the block returns exactly one result
// beat per tick with the six LED drives and the flag as they stand after the
// tick. One beat is accepted per clock. The beat is held in an input register;
// when it advances, the tick logic updates the sequencer state and loads the
// result register, from which the result is offered until it is taken. The
// input stays open while the input register is empty or can hand its beat to
// the result stage in the same cycle; a waiting result with a beat behind it
// stalls the input. The tick divider sits at APB byte address 0 (reset value
// 4); the user must write it only while no beat is in flight, and the block
// itself does not enforce this.
module led_pattern_sequencer_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    lps_in_if.sink                              in_ch,
    lps_out_if.source                           out_ch,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lps_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [lps_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [lps_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import lps_pkg::*;

    logic       [3:0] tick_divide;
    logic             s1_vld_reg;
    logic             s1_vld_next;
    lps_item_t        s1_item_reg;
    lps_item_t        in_item;
    lps_state_t       state_reg;
    lps_state_t       state_next;
    logic             out_vld_reg;
    logic             out_vld_next;
    logic [LED_W-1:0] out_led_reg;
    logic       [7:0] out_flag_reg;
    logic             s1_adv;
    logic             in_fire;

    // Configuration registers
    lps_apb u_apb (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .tick_divide (tick_divide)
    );

    // Flow control between the two stages
    assign s1_adv      = s1_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready = !s1_vld_reg || s1_adv;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign s1_vld_next = in_fire || (s1_vld_reg && !s1_adv);
    assign out_vld_next = s1_adv || (out_vld_reg && !out_ch.ready);

    assign in_item.mode             = in_ch.mode;
    assign in_item.flag_write_valid = in_ch.flag_write_valid;
    assign in_item.flag_write_value = in_ch.flag_write_value;
    assign in_item.level_pattern    = in_ch.level_pattern;

    // Tick logic
    lps_step u_step (
        .item        (s1_item_reg),
        .cur         (state_reg),
        .tick_divide (tick_divide),
        .nxt         (state_next)
    );

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
            if (s1_adv)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers: capture input beat, load result
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_adv)
        begin
            out_led_reg  <= state_next.led_latch;
            out_flag_reg <= state_next.handshake;
        end
    end

    assign out_ch.valid          = out_vld_reg;
    assign out_ch.led_drive      = out_led_reg;
    assign out_ch.handshake_flag = out_flag_reg;

`ifndef ASSERT_OFF
    // Step counter never reaches the end of the walk
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.step_count < WALK_STEPS)
        else $error("step_count out of range");

    // Kept pattern bits four and five are never set
    a_keep_bits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pattern_byte[5:4] == 2'b00)
        else $error("pattern_byte kept bits set");

    // A beat leaving the input stage shows up as a result next cycle
    a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (out_vld_reg && out_led_reg == $past(state_next.led_latch)))
        else $error("result not loaded after input stage advance");
`endif

endmodule : led_pattern_sequencer_core

`default_nettype wire

/* hw/rtl/lps_apb.sv */
// APB register block holding the tick divider.
`timescale 1ns / 1ps
`default_nettype none

module lps_apb (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lps_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [lps_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [lps_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output logic      [3:0]                     tick_divide
);
    import lps_pkg::*;

    logic [3:0] tick_divide_reg;
    logic [3:0] tick_divide_next;
    logic       wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr == ADDR_TICK_DIVIDE);

    // Update divider on a completed write beat
    always_comb
    begin
        tick_divide_next = tick_divide_reg;
        if (wr_hit)
        begin
            tick_divide_next = pwdata[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_divide_reg <= TICK_DIVIDE_RST;
        end
        else
        begin
            tick_divide_reg <= tick_divide_next;
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_TICK_DIVIDE)
        begin
            prdata = {{(APB_DATA_W-4){1'b0}}, tick_divide_reg};
        end
    end

    assign tick_divide = tick_divide_reg;

endmodule : lps_apb

`default_nettype wire

/* hw/rtl/lps_step.sv */
// Next-state logic for one tick of the LED pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none

module lps_step (
    input  wire lps_pkg::lps_item_t  item,
    input  wire lps_pkg::lps_state_t cur,
    input  wire logic [3:0]          tick_divide,
    output lps_pkg::lps_state_t      nxt
);
    import lps_pkg::*;

    logic       tick_hit;
    logic [3:0] tick_inc;
    logic [3:0] step_inc;
    logic [3:0] walk_pos;
    logic       do_blink;
    logic [7:0] blink_on;
    logic [7:0] pair_bits;
    logic       blink_phase_n;

    // Divider: advance when the count has reached the divide value
    assign tick_hit = (cur.tick_count >= tick_divide);
    assign tick_inc = tick_hit ? 4'd0 : (cur.tick_count + 4'd1);
    assign step_inc = cur.step_count + 4'd1;
    assign walk_pos = (cur.step_count >= LED_COUNT) ? (cur.step_count - LED_COUNT)
                                                    : cur.step_count;
    assign pair_bits = cur.step_count[0] ? PAIR_LOW : PAIR_HIGH;
    assign blink_phase_n = ~cur.blink_phase;

    always_comb
    begin
        nxt      = cur;
        do_blink = 1'b0;
        blink_on = ON_LED0;

        // Software flag write lands before the mode acts
        if (item.flag_write_valid)
        begin
            nxt.handshake = item.flag_write_value;
        end

        case (item.mode)
            MODE_CLEAR:
            begin
                if (nxt.handshake == HS_IDLE)
                begin
                    nxt.led_latch = '0;
                end
                nxt.handshake = HS_CLEARED;
            end
            MODE_WALK:
            begin
                if (nxt.handshake == HS_IDLE)
                begin
                    nxt.tick_count = tick_inc;
                    if (tick_hit)
                    begin
                        nxt.led_latch  = (walk_pos < LED_COUNT) ? (6'd1 << walk_pos) : 6'd0;
                        nxt.step_count = step_inc;
                        if (step_inc >= WALK_STEPS || step_inc == 4'd0)
                        begin
                            nxt.step_count = 4'd0;
                            nxt.handshake  = HS_WALK_DONE;
                            nxt.tick_count = 4'd0;
                            nxt.led_latch  = '0;
                        end
                    end
                end
            end
            MODE_BLINK0:
            begin
                do_blink = 1'b1;
                blink_on = ON_LED0;
            end
            MODE_LEVEL:
            begin
                nxt.pattern_byte = cur.pattern_byte | (item.level_pattern & LEVEL_HI);
                nxt.led_latch    = item.level_pattern[LED_W-1:0];
            end
            MODE_BLINK03:
            begin
                do_blink = 1'b1;
                blink_on = ON_LED03;
            end
            MODE_FIXED_A:
            begin
                nxt.pattern_byte = (cur.pattern_byte & KEEP_MASK) | FIXED_A;
                nxt.led_latch    = nxt.pattern_byte[LED_W-1:0];
            end
            MODE_FIXED_B:
            begin
                nxt.pattern_byte = (cur.pattern_byte & KEEP_MASK) | FIXED_B;
                nxt.led_latch    = nxt.pattern_byte[LED_W-1:0];
            end
            MODE_PAIRS:
            begin
                if (nxt.handshake == HS_IDLE)
                begin
                    nxt.tick_count = tick_inc;
                    if (tick_hit)
                    begin
                        nxt.pattern_byte = (cur.pattern_byte & KEEP_MASK) | pair_bits;
                        nxt.led_latch    = nxt.pattern_byte[LED_W-1:0];
                        nxt.step_count   = step_inc;
                        if (step_inc >= PAIR_STEPS || step_inc == 4'd0)
                        begin
                            nxt.step_count = 4'd0;
                            nxt.handshake  = HS_PAIR_DONE;
                            nxt.tick_count = 4'd0;
                            nxt.led_latch  = '0;
                        end
                    end
                end
            end
            default:
            begin
                // Undefined modes hold everything but the flag write
            end
        endcase

        // Shared blink: toggle phase on each divided advance
        if (do_blink)
        begin
            nxt.tick_count = tick_inc;
            if (tick_hit)
            begin
                nxt.blink_phase  = blink_phase_n;
                nxt.pattern_byte = (cur.pattern_byte & KEEP_MASK) |
                                   (blink_phase_n ? blink_on : 8'h00);
                nxt.led_latch    = nxt.pattern_byte[LED_W-1:0];
            end
        end
    end

endmodule : lps_step

`default_nettype wire

/* tb/sv/led_pattern_sequencer_core_tb.sv */
// Self-checking testbench for the LED pattern sequencer core.
`timescale 1ns / 1ps

module led_pattern_sequencer_core_tb;
    import lps_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 9;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASES         = 7;
    localparam int PHASE_TICKS    = 125;
    localparam int LONG_PARK      = 80;
    localparam int TIMEOUT_NS     = 2_000_000;
    localparam int DIRECTED_COUNT = 23;

    // Modes outside the defined set
    localparam logic [7:0] MODE_UNDEF_LO  = 8'h08;
    localparam logic [7:0] MODE_UNDEF_MID = 8'h80;
    localparam logic [7:0] MODE_UNDEF_HI  = 8'hFF;

    typedef struct packed {
        logic [LED_W-1:0] led;
        logic [7:0]       flag;
    } led_frame_t;

    // One directed tick; has_frame marks a row whose answer is typed in
    typedef struct packed {
        logic [7:0]       mode;
        logic             flag_write_valid;
        logic [7:0]       flag_write_value;
        logic [7:0]       level_pattern;
        logic             has_frame;
        logic [LED_W-1:0] led;
        logic [7:0]       flag;
    } tick_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lps_in_if  in_ch ();
    lps_out_if out_ch ();

    led_pattern_sequencer_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Sequencer state as the testbench sees it
    logic [3:0]       divide_cfg;
    logic [LED_W-1:0] led_reg;
    logic [7:0]       pattern_reg;
    logic             blink_on;
    logic [3:0]       tick_cnt;
    logic [3:0]       step_cnt;
    logic [7:0]       flag_reg;

    led_frame_t frames_due [$];
    int         mismatches  = 0;
    int         tx_idle_pct = 20;
    int         rx_idle_pct = 20;
    int         park_cycles = 0;

    tick_row_t directed_rows [DIRECTED_COUNT] = '{
        '{MODE_UNDEF_HI, 1'b0, 8'h00, 8'hFF, 1'b1, 6'h00, HS_IDLE},
        '{MODE_CLEAR,    1'b0, 8'h00, 8'h00, 1'b1, 6'h00, HS_CLEARED},
        '{MODE_WALK,     1'b0, 8'h00, 8'h00, 1'b1, 6'h00, HS_CLEARED},
        '{MODE_PAIRS,    1'b0, 8'h00, 8'h00, 1'b1, 6'h00, HS_CLEARED},
        '{MODE_UNDEF_LO, 1'b1, 8'hFF, 8'h00, 1'b1, 6'h00, 8'hFF},
        '{MODE_LEVEL,    1'b0, 8'h00, 8'hFF, 1'b1, 6'h3F, 8'hFF},
        '{MODE_LEVEL,    1'b0, 8'h00, 8'h00, 1'b1, 6'h00, 8'hFF},
        '{MODE_FIXED_A,  1'b0, 8'h00, 8'h00, 1'b1, 6'h09, 8'hFF},
        '{MODE_FIXED_B,  1'b0, 8'h00, 8'h00, 1'b1, 6'h06, 8'hFF},
        '{MODE_BLINK0,   1'b0, 8'h00, 8'hAA, 1'b0, 6'h00, 8'h00},
        '{MODE_BLINK0,   1'b0, 8'h00, 8'h55, 1'b0, 6'h00, 8'h00},
        '{MODE_BLINK0,   1'b0, 8'h00, 8'hAA, 1'b0, 6'h00, 8'h00},
        '{MODE_BLINK0,   1'b0, 8'h00, 8'h55, 1'b0, 6'h00, 8'h00},
        '{MODE_BLINK0,   1'b0, 8'h00, 8'hAA, 1'b0, 6'h00, 8'h00},
        '{MODE_BLINK03,  1'b0, 8'h00, 8'h00, 1'b0, 6'h00, 8'h00},
        '{MODE_BLINK03,  1'b0, 8'h00, 8'hFF, 1'b0, 6'h00, 8'h00},
        '{MODE_BLINK03,  1'b0, 8'h00, 8'h00, 1'b0, 6'h00, 8'h00},
        '{MODE_BLINK03,  1'b0, 8'h00, 8'hFF, 1'b0, 6'h00, 8'h00},
        '{MODE_BLINK03,  1'b0, 8'h00, 8'h00, 1'b0, 6'h00, 8'h00},
        '{MODE_CLEAR,    1'b1, 8'h00, 8'h00, 1'b1, 6'h00, HS_CLEARED},
        '{MODE_WALK,     1'b1, 8'h00, 8'h00, 1'b0, 6'h00, 8'h00},
        '{MODE_PAIRS,    1'b1, 8'h00, 8'h55, 1'b0, 6'h00, 8'h00},
        '{MODE_UNDEF_MID, 1'b1, 8'h80, 8'h40, 1'b0, 6'h00, 8'h00}
    };

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Count one tick toward the divider; true on the tick that advances
    function automatic bit divided_advance();
        if (tick_cnt < divide_cfg)
        begin
            tick_cnt = tick_cnt + 4'd1;
            return 1'b0;
        end
        tick_cnt = 4'd0;
        return 1'b1;
    endfunction

    function automatic void blink_step(input logic [7:0] on_bits);
        if (divided_advance())
        begin
            blink_on    = ~blink_on;
            pattern_reg = (pattern_reg & KEEP_MASK) | (blink_on ? on_bits : 8'h00);
            led_reg     = pattern_reg[LED_W-1:0];
        end
    endfunction

    // Apply one tick to the state and return the LED frame that follows it
    function automatic led_frame_t predict_tick(input lps_item_t it);
        logic [3:0] walk_pos;
        led_frame_t frame;
        if (it.flag_write_valid)
            flag_reg = it.flag_write_value;
        case (it.mode)
            MODE_CLEAR:
            begin
                if (flag_reg == HS_IDLE)
                    led_reg = '0;
                flag_reg = HS_CLEARED;
            end
            MODE_WALK:
            begin
                if (flag_reg == HS_IDLE)
                begin
                    if (divided_advance())
                    begin
                        // fold the second pass onto the same six LEDs
                        walk_pos = step_cnt;
                        if (walk_pos >= LED_COUNT)
                            walk_pos = walk_pos - LED_COUNT;
                        led_reg  = (walk_pos < LED_COUNT) ? (LED_W'(1) << walk_pos) : '0;
                        step_cnt = step_cnt + 4'd1;
                        if (step_cnt >= WALK_STEPS || step_cnt == 4'd0)
                        begin
                            step_cnt = 4'd0;
                            flag_reg = HS_WALK_DONE;
                            tick_cnt = 4'd0;
                            led_reg  = '0;
                        end
                    end
                end
            end
            MODE_BLINK0:
                blink_step(ON_LED0);
            MODE_LEVEL:
            begin
                pattern_reg = pattern_reg | (it.level_pattern & LEVEL_HI);
                led_reg     = it.level_pattern[LED_W-1:0];
            end
            MODE_BLINK03:
                blink_step(ON_LED03);
            MODE_FIXED_A:
            begin
                pattern_reg = (pattern_reg & KEEP_MASK) | FIXED_A;
                led_reg     = pattern_reg[LED_W-1:0];
            end
            MODE_FIXED_B:
            begin
                pattern_reg = (pattern_reg & KEEP_MASK) | FIXED_B;
                led_reg     = pattern_reg[LED_W-1:0];
            end
            MODE_PAIRS:
            begin
                if (flag_reg == HS_IDLE)
                begin
                    if (divided_advance())
                    begin
                        pattern_reg = (pattern_reg & KEEP_MASK) |
                                      (step_cnt[0] ? PAIR_LOW : PAIR_HIGH);
                        led_reg     = pattern_reg[LED_W-1:0];
                        step_cnt    = step_cnt + 4'd1;
                        if (step_cnt >= PAIR_STEPS || step_cnt == 4'd0)
                        begin
                            step_cnt = 4'd0;
                            flag_reg = HS_PAIR_DONE;
                            tick_cnt = 4'd0;
                            led_reg  = '0;
                        end
                    end
                end
            end
            default:
                ;
        endcase
        frame.led  = led_reg;
        frame.flag = flag_reg;
        return frame;
    endfunction

    // Offer one tick beat, hold it until taken, then queue its frame
    task automatic offer_tick(input lps_item_t it, input bit typed, input led_frame_t typed_frame);
        int         gap;
        led_frame_t predicted;
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.mode             <= it.mode;
        in_ch.flag_write_valid <= it.flag_write_valid;
        in_ch.flag_write_value <= it.flag_write_value;
        in_ch.level_pattern    <= it.level_pattern;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        predicted = predict_tick(it);
        frames_due.push_back(typed ? typed_frame : predicted);
    endtask

    // Drop valid and wait until every queued frame has come back
    task automatic wait_frames_drained();
        in_ch.valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_tick_divide(input logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TICK_DIVIDE;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        divide_cfg = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Result side: check each beat taken, then decide ready for the next edge
    initial
    begin : result_sink
        int         stall_left;
        int         park_left;
        led_frame_t want;
        stall_left = 0;
        park_left  = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("unexpected result beat: led_drive %0h handshake_flag %0h",
                           out_ch.led_drive, out_ch.handshake_flag);
                    mismatches++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (out_ch.led_drive !== want.led)
                    begin
                        $error("led_drive mismatch: expected %0h, actual %0h",
                               want.led, out_ch.led_drive);
                        mismatches++;
                    end
                    if (out_ch.handshake_flag !== want.flag)
                    begin
                        $error("handshake_flag mismatch: expected %0h, actual %0h",
                               want.flag, out_ch.handshake_flag);
                        mismatches++;
                    end
                end
            end
            // take over a long hold-off request
            if (park_cycles > 0)
            begin
                park_left   = park_cycles;
                park_cycles = 0;
            end
            if (park_left > 0)
            begin
                park_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                stall_left = $urandom_range(0, 3);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Stimulus: directed table, then random phases at several divider settings
    initial
    begin : stimulus
        tick_row_t  row;
        lps_item_t  it;
        led_frame_t typed_frame;
        logic [7:0] run_mode;
        logic [3:0] div_now;
        int         sent;
        int         run_len;
        int         pick;
        int         i;

        rst_n                  <= 1'b0;
        in_ch.valid            <= 1'b0;
        in_ch.mode             <= '0;
        in_ch.flag_write_valid <= 1'b0;
        in_ch.flag_write_value <= '0;
        in_ch.level_pattern    <= '0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;

        divide_cfg  = TICK_DIVIDE_RST;
        led_reg     = '0;
        pattern_reg = '0;
        blink_on    = 1'b0;
        tick_cnt    = '0;
        step_cnt    = '0;
        flag_reg    = HS_IDLE;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (i = 0; i < DIRECTED_COUNT; i++)
        begin
            row                 = directed_rows[i];
            it.mode             = row.mode;
            it.flag_write_valid = row.flag_write_valid;
            it.flag_write_value = row.flag_write_value;
            it.level_pattern    = row.level_pattern;
            typed_frame.led     = row.led;
            typed_frame.flag    = row.flag;
            offer_tick(it, row.has_frame, typed_frame);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_frames_drained();
            case (phase)
                0:       div_now = 4'd0;
                1:       div_now = 4'd15;
                5:       div_now = 4'($urandom_range(0, 15));
                default: div_now = 4'($urandom_range(0, 3));
            endcase
            write_tick_divide(div_now);

            // no idling in one middle stretch and in the tail
            if (phase == 3 || phase == PHASES - 1)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else
            begin
                tx_idle_pct = $urandom_range(10, 30);
                rx_idle_pct = $urandom_range(10, 30);
            end
            if (phase == 2)
                park_cycles = LONG_PARK;

            sent = 0;
            while (sent < PHASE_TICKS)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    // well-formed run of one mode, started from an idle flag
                    case (pick)
                        0, 1:
                        begin
                            run_mode = MODE_WALK;
                            run_len  = (int'(div_now) + 1) * int'(WALK_STEPS) +
                                       $urandom_range(0, 3);
                        end
                        2, 3:
                        begin
                            run_mode = MODE_PAIRS;
                            run_len  = (int'(div_now) + 1) * int'(PAIR_STEPS) +
                                       $urandom_range(0, 3);
                        end
                        4:
                        begin
                            run_mode = MODE_BLINK0;
                            run_len  = $urandom_range(1, 3 * (int'(div_now) + 1) + 2);
                        end
                        default:
                        begin
                            run_mode = MODE_BLINK03;
                            run_len  = $urandom_range(1, 3 * (int'(div_now) + 1) + 2);
                        end
                    endcase
                    // break some runs off early
                    if ($urandom_range(0, 4) == 0)
                        run_len = $urandom_range(1, run_len);
                    // keep the phase within its tick budget
                    if (run_len > PHASE_TICKS - sent)
                        run_len = PHASE_TICKS - sent;
                    for (i = 0; i < run_len; i++)
                    begin
                        it.mode             = run_mode;
                        it.flag_write_valid = (i == 0);
                        it.flag_write_value = HS_IDLE;
                        it.level_pattern    = 8'($urandom);
                        offer_tick(it, 1'b0, '0);
                        sent++;
                    end
                end
                else
                begin
                    // noise: any mode, random flag writes and levels
                    it.mode             = ($urandom_range(0, 3) == 0) ?
                                          8'($urandom) : 8'($urandom_range(0, 7));
                    it.flag_write_valid = 1'($urandom);
                    it.flag_write_value = ($urandom_range(0, 1) == 1) ?
                                          8'($urandom) : HS_IDLE;
                    it.level_pattern    = 8'($urandom);
                    offer_tick(it, 1'b0, '0);
                    sent++;
                end
            end
        end

        wait_frames_drained();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("Some tests failed");
        $finish;
    end

endmodule : led_pattern_sequencer_core_tb
